@@ rtl/tct_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console package
// Screen geometry, control byte codes and the types shared by the console
// modules.
// ----------------------------------------------------------------------------
package tct_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int LINES   = 25;
  localparam int CELLS   = COLUMNS * LINES;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(LINES);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Reported positions are 11 bits wide whatever the geometry.
  localparam int POS_W = 11;
  localparam int LIN_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;

  // Item modes.
  localparam logic MODE_PUT   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Control bytes.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_STEP = 4;

  // Cell value used by the clearing pass after reset.
  localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

  // Command to the screen store sequencer.
  typedef struct packed {
    logic              start;
    logic              scroll;
    logic [CELL_W-1:0] blank;
  } store_cmd_t;

  // Outcome of one character on the cursor.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              written;
    logic [COL_W-1:0]  addr_col;
    logic [ROW_W-1:0]  addr_row;
    logic [CELL_W-1:0] value;
    logic              scroll;
  } step_t;

endpackage

@@ rtl/tct_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tct_cursor.sv @@
// ----------------------------------------------------------------------------
// Cursor step
// Works out where the cursor goes for one byte, which cell it writes and
// whether the screen has to scroll.
// ----------------------------------------------------------------------------
module tct_cursor (
  input  logic [tct_pkg::COL_W-1:0] col,
  input  logic [tct_pkg::ROW_W-1:0] row,
  input  logic [7:0]                char_code,
  input  logic [7:0]                attr,
  output tct_pkg::step_t            step
);

  logic [tct_pkg::COL_W:0] colx;
  logic [tct_pkg::ROW_W:0] rowx;

  // Apply the byte, then wrap at the line end and at the last row.
  always_comb begin
    colx          = {1'b0, col};
    rowx          = {1'b0, row};
    step.written  = 1'b0;
    step.addr_col = col;
    step.addr_row = row;
    step.value    = '0;
    step.scroll   = 1'b0;

    case (char_code)
      tct_pkg::CH_BS: begin
        if (col != '0 || row != '0) begin
          if (col == '0) begin
            rowx = rowx - 1'b1;
            colx = (tct_pkg::COL_W+1)'(tct_pkg::COLUMNS - 1);
          end else begin
            colx = colx - 1'b1;
          end
          step.addr_col = colx[tct_pkg::COL_W-1:0];
          step.addr_row = rowx[tct_pkg::ROW_W-1:0];
          step.value    = {attr, tct_pkg::CH_SPACE};
          step.written  = 1'b1;
        end
      end
      tct_pkg::CH_TAB: begin
        colx = colx + (tct_pkg::COL_W+1)'(tct_pkg::TAB_STEP);
      end
      tct_pkg::CH_CR: begin
        colx = '0;
      end
      tct_pkg::CH_LF: begin
        rowx = rowx + 1'b1;
        colx = '0;
      end
      default: begin
        step.value   = {attr, char_code};
        step.written = 1'b1;
        colx         = colx + 1'b1;
      end
    endcase

    if (colx >= (tct_pkg::COL_W+1)'(tct_pkg::COLUMNS)) begin
      colx = '0;
      rowx = rowx + 1'b1;
    end
    if (rowx >= (tct_pkg::ROW_W+1)'(tct_pkg::LINES)) begin
      rowx        = (tct_pkg::ROW_W+1)'(tct_pkg::LINES - 1);
      step.scroll = 1'b1;
    end

    step.col = colx[tct_pkg::COL_W-1:0];
    step.row = rowx[tct_pkg::ROW_W-1:0];
  end

endmodule

@@ rtl/tct_store.sv @@
// ----------------------------------------------------------------------------
// Screen store
// Holds the cell memory and sweeps it one cell a cycle to clear it or to
// scroll it up one line; single cell writes pass straight through.
// ----------------------------------------------------------------------------
module tct_store (
  input  logic                              clk,
  input  logic                              rst,
  input  tct_pkg::store_cmd_t               cmd,
  input  logic                              cell_we,
  input  logic [tct_pkg::ADDR_W-1:0]        cell_addr,
  input  logic [tct_pkg::CELL_W-1:0]        cell_data,
  output logic                              busy
);

  localparam logic [tct_pkg::ADDR_W-1:0] LAST_CELL =
    tct_pkg::ADDR_W'(tct_pkg::CELLS - 1);
  localparam logic [tct_pkg::ADDR_W-1:0] COPY_CELLS =
    tct_pkg::ADDR_W'(tct_pkg::CELLS - tct_pkg::COLUMNS);
  localparam logic [tct_pkg::ADDR_W-1:0] LINE_CELLS =
    tct_pkg::ADDR_W'(tct_pkg::COLUMNS);

  logic                       running;
  logic                       is_scroll;
  logic [tct_pkg::CELL_W-1:0] blank;
  logic [tct_pkg::ADDR_W-1:0] cnt;
  logic                       copy_now;

  logic                       wv;
  logic                       wcopy;
  logic [tct_pkg::ADDR_W-1:0] wa;

  logic                       ram_we;
  logic [tct_pkg::ADDR_W-1:0] ram_waddr;
  logic [tct_pkg::CELL_W-1:0] ram_wdata;
  logic [tct_pkg::CELL_W-1:0] ram_rdata;

  // Cells above the last line are copied from one line further down.
  assign copy_now = running && is_scroll && (cnt < COPY_CELLS);

  // Sweep counter: every sweep covers all cells once. Reset starts the
  // clearing pass with the power-on blank.
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b1;
      is_scroll <= 1'b0;
      blank     <= tct_pkg::RESET_BLANK;
      cnt       <= '0;
    end else if (cmd.start) begin
      running   <= 1'b1;
      is_scroll <= cmd.scroll;
      blank     <= cmd.blank;
      cnt       <= '0;
    end else if (running) begin
      if (cnt == LAST_CELL) begin
        running <= 1'b0;
        cnt     <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Write stage, in the cycle after the read issued by the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= running;
    end
    wa    <= cnt;
    wcopy <= copy_now;
  end

  assign busy = running || wv;

  // Single cell writes must only come while no sweep runs; the store does not enforce this.
  always_comb begin
    if (cell_we) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr;
      ram_wdata = cell_data;
    end else begin
      ram_we    = wv;
      ram_waddr = wa;
      ram_wdata = wcopy ? ram_rdata : blank;
    end
  end

  tct_ram #(
    .WIDTH(tct_pkg::CELL_W),
    .DEPTH(tct_pkg::CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt + LINE_CELLS),
    .rdata(ram_rdata)
  );

  // A single write never lands on top of a sweep write.
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    !(cell_we && wv))
    else $error("cell write collided with a sweep write");

  // A sweep only ends after the last cell.
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    $fell(running) && !$past(cmd.start) |-> $past(cnt) == LAST_CELL)
    else $error("sweep ended early");

endmodule

@@ rtl/text_console_teletype.sv @@
// ----------------------------------------------------------------------------
// Text console teletype
// Character-cell console with a cursor, a screen store and scrolling.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream, one byte in s_tdata with s_tuser
// set for a clear-screen command. Each item gives exactly one result item on
// the m_ stream: the cursor position after the item, the cell written (if
// any), and scroll and clear flags. Colors are set through the write port
// (cfg_we, cfg_index, cfg_data); the user is to write them only while the
// console is idle; the block does not enforce it. A plain item passes the
// STEP and DONE states before the output register raises m_tvalid. A
// clear or a scroll first sweeps the whole store one cell a cycle. The
// sweep length is set by the single write port of the screen memory.
// Throughput: one item at a time; s_tready is high only while the console
// is waiting for an item. A result waiting on a stalled receiver does not
// stop the next item from being accepted, but that item's result waits
// until the output register is free.
// Reset: a clearing pass writes 0x0720 to every cell; s_tready stays low
// during it. The cursor goes home, colors go to 7 on 0.
// ----------------------------------------------------------------------------
module text_console_teletype (
  input  logic                              clk,
  input  logic                              rst,
  // Input item: s_tdata = char_code[7:0]; s_tuser = mode.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tct_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  // Result item: m_tdata = cursor_position[10:0], cell_written[11],
  // cell_address[22:12], cell_value[38:23], did_scroll[39], did_clear[40],
  // zero padding up to bit 47.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tct_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [tct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  logic                       mode_q;
  logic [7:0]                 ch_q;
  logic [3:0]                 fg;
  logic [3:0]                 bg;
  logic [7:0]                 attr;
  logic [tct_pkg::COL_W-1:0]  col;
  logic [tct_pkg::ROW_W-1:0]  row;

  logic                       res_written;
  logic [tct_pkg::POS_W-1:0]  res_addr;
  logic [tct_pkg::CELL_W-1:0] res_value;
  logic                       res_scroll;
  logic                       res_clear;

  logic [tct_pkg::POS_W-1:0]  out_pos;
  logic                       out_written;
  logic [tct_pkg::POS_W-1:0]  out_addr;
  logic [tct_pkg::CELL_W-1:0] out_value;
  logic                       out_scroll;
  logic                       out_clear;

  tct_pkg::step_t             step;
  tct_pkg::store_cmd_t        cmd;
  logic                       busy;
  logic                       cell_we;

  logic [tct_pkg::COL_W-1:0]  mcol;
  logic [tct_pkg::ROW_W-1:0]  mrow;
  logic [tct_pkg::LIN_W-1:0]  lin;

  logic                       accept;
  logic                       out_free;

  assign attr     = {bg, fg};
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= 4'd7;
      bg <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tct_pkg::REG_FOREGROUND: fg <= cfg_data;
        tct_pkg::REG_BACKGROUND: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  tct_cursor u_cursor (
    .col      (col),
    .row      (row),
    .char_code(ch_q),
    .attr     (attr),
    .step     (step)
  );

  // Linear index unit: gives the written cell's address during the step and
  // the cursor position when the result is formed.
  always_comb begin
    if (state == ST_STEP) begin
      mcol = step.addr_col;
      mrow = step.addr_row;
    end else begin
      mcol = col;
      mrow = row;
    end
  end

  assign lin = tct_pkg::LIN_W'(mrow) * tct_pkg::LIN_W'(tct_pkg::COLUMNS)
             + tct_pkg::LIN_W'(mcol);

  // Store commands: the character write and the start of a clear or scroll.
  assign cell_we = (state == ST_STEP) && (mode_q == tct_pkg::MODE_PUT) && step.written;

  always_comb begin
    cmd.blank  = {attr, tct_pkg::CH_SPACE};
    cmd.scroll = (mode_q == tct_pkg::MODE_PUT);
    cmd.start  = (state == ST_STEP)
              && ((mode_q == tct_pkg::MODE_CLEAR) || step.scroll);
  end

  tct_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cell_we  (cell_we),
    .cell_addr(lin[tct_pkg::ADDR_W-1:0]),
    .cell_data(step.value),
    .busy     (busy)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (!busy) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_STEP;
      ST_STEP:  state_next = cmd.start ? ST_SWEEP : ST_DONE;
      ST_SWEEP: if (!busy) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= s_tuser;
      ch_q   <= s_tdata;
    end
  end

  // Cursor update and per-item flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (state == ST_STEP) begin
      if (mode_q == tct_pkg::MODE_CLEAR) begin
        col <= '0;
        row <= '0;
      end else begin
        col <= step.col;
        row <= step.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STEP) begin
      if (mode_q == tct_pkg::MODE_CLEAR) begin
        res_written <= 1'b0;
        res_addr    <= '0;
        res_value   <= '0;
        res_scroll  <= 1'b0;
        res_clear   <= 1'b1;
      end else begin
        res_written <= step.written;
        res_addr    <= step.written ? lin[tct_pkg::POS_W-1:0] : '0;
        res_value   <= step.value;
        res_scroll  <= step.scroll;
        res_clear   <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_pos     <= lin[tct_pkg::POS_W-1:0];
      out_written <= res_written;
      out_addr    <= res_addr;
      out_value   <= res_value;
      out_scroll  <= res_scroll;
      out_clear   <= res_clear;
    end
  end

  assign m_tdata = {7'd0, out_clear, out_scroll, out_value, out_addr, out_written, out_pos};

  // No item is taken while the store is sweeping.
  a_accept_idle_store: assert property (@(posedge clk) disable iff (rst)
    accept |-> !busy)
    else $error("item accepted during a store sweep");

  // A scrolled result leaves the cursor on the last row.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && res_scroll |-> row == tct_pkg::ROW_W'(tct_pkg::LINES - 1))
    else $error("scroll without cursor on last row");

  // A clear homes the cursor.
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && res_clear |-> (col == '0) && (row == '0))
    else $error("clear left the cursor away from home");

endmodule
